// ===== hdl/sha256_message_hasher_defines.svh =====
// Assertion macros used by the hasher checker.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/smh_pkg.sv =====
// Constants, round table and sigma functions for the SHA-256 hasher.
package smh_pkg;

	localparam logic [7:0] PAD_MARK      = 8'h80;
	localparam logic [5:0] LEN_FILL      = 6'd56;
	localparam logic [5:0] FILL_LAST     = 6'd63;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/sha256_message_hasher.sv =====
// SHA-256 hasher: byte-serial message input, eight-word digest output.
//
// Input channel (msg_valid/msg_ready): one item per message byte, with
// byte_valid telling whether msg_byte is used and end_of_message closing the
// message; an end mark may come without a byte. Output channel
// (digest_valid/digest_ready): eight items per message, word_index 0..7,
// last_word on the eighth.
// A byte that does not complete a 64-byte block is taken with msg_ready staying
// high. The byte that completes a block starts the compression: the rounds run
// on the single shared round unit, then a fold step adds the working words
// into the chaining words, and msg_ready is low throughout. On an end mark the
// tail is padded one byte per cycle (up to 64 bytes, with a compression between
// if the tail exceeds 55 bytes), the 8 length bytes follow, then the final
// compression; the first digest word appears in the cycle after its fold step.
// The digest words are driven from the chaining registers; a stalled
// receiver holds the current word, and msg_ready stays low until the
// eighth word is taken, after which the chaining words return to their
// initial values.
// Reset (arst_n low) clears the byte count and loads the initial chaining
// words; the block buffer is not reset, and no clearing pass is needed.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MSG,
		PH_PAD,
		PH_FINAL
	} phase_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [5:0]          fill_q;
	logic [60:0]         total_q;
	logic [5:0]          round_q;
	logic                pad_first_q;
	logic                end_pend_q;
	logic [2:0]          word_idx_q;
	logic [7:0][31:0]    h_q;
	logic [7:0][31:0]    v_q;
	logic [15:0][31:0]   w_q;

	logic                shift_en;
	logic [7:0]          shift_byte;
	logic                comp_start;
	logic [63:0]         len_bits;
	logic [31:0]         w_next;
	logic [31:0]         t1;
	logic [31:0]         t2;

	assign len_bits   = {total_q, 3'b000};
	assign comp_start = shift_en && (fill_q == smh_pkg::FILL_LAST);

	always_comb begin
		shift_en   = 1'b0;
		shift_byte = msg_byte;
		case (state_q)
			ST_IDLE: begin
				shift_en   = msg_valid & byte_valid;
				shift_byte = msg_byte;
			end
			ST_PAD: begin
				shift_en   = pad_first_q | (fill_q != smh_pkg::LEN_FILL);
				shift_byte = pad_first_q ? smh_pkg::PAD_MARK : 8'h00;
			end
			ST_LEN: begin
				// big-endian bit count, top byte first
				shift_en   = 1'b1;
				shift_byte = len_bits[{3'd7 - fill_q[2:0], 3'b000} +: 8];
			end
			default: begin
				shift_en   = 1'b0;
			end
		endcase
	end

	// Window holds w[t] in the top word, w[t+15] in the bottom word.
	assign w_next = smh_pkg::small_s1(w_q[1]) + w_q[6] + smh_pkg::small_s0(w_q[14]) + w_q[15];

	assign t1 = v_q[7] + smh_pkg::big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ smh_pkg::round_k(round_q) + w_q[15];
	assign t2 = smh_pkg::big_s0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (shift_en) begin
			w_q <= {w_q[15][23:0], w_q[14:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			w_q <= {w_q[14:0], w_next};
		end
		if (comp_start) begin
			v_q <= h_q;
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MSG;
			fill_q      <= '0;
			total_q     <= '0;
			round_q     <= '0;
			pad_first_q <= 1'b0;
			end_pend_q  <= 1'b0;
			word_idx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= smh_pkg::iv_word(3'(i));
			end
		end else begin
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						if (byte_valid) begin
							total_q <= total_q + 61'd1;
						end
						if (comp_start) begin
							state_q     <= ST_ROUND;
							round_q     <= '0;
							phase_q     <= PH_MSG;
							end_pend_q  <= end_of_message;
							pad_first_q <= end_of_message;
						end else if (end_of_message) begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (shift_en) begin
						pad_first_q <= 1'b0;
						if (comp_start) begin
							state_q <= ST_ROUND;
							round_q <= '0;
							phase_q <= PH_PAD;
						end
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (comp_start) begin
						state_q <= ST_ROUND;
						round_q <= '0;
						phase_q <= PH_FINAL;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == smh_pkg::LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					case (phase_q)
						PH_MSG: begin
							state_q    <= end_pend_q ? ST_PAD : ST_IDLE;
							end_pend_q <= 1'b0;
						end
						PH_PAD: begin
							state_q <= ST_PAD;
						end
						PH_FINAL: begin
							state_q    <= ST_OUT;
							total_q    <= '0;
							word_idx_q <= '0;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_OUT: begin
					if (digest_ready) begin
						if (word_idx_q == smh_pkg::LAST_WORD_IDX) begin
							// restart the chain for the next message
							state_q    <= ST_IDLE;
							word_idx_q <= '0;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= smh_pkg::iv_word(3'(i));
							end
						end else begin
							word_idx_q <= word_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign msg_ready    = (state_q == ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign digest_word  = h_q[word_idx_q];
	assign word_index   = word_idx_q;
	assign last_word    = (word_idx_q == smh_pkg::LAST_WORD_IDX);

endmodule

// ===== hdl/smh_checker.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level.
`include "sha256_message_hasher_defines.svh"

module smh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_ready,
	input logic        digest_valid,
	input logic        digest_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	`SMH_ASSERT_NOW(a_no_overlap, clk, arst_n, digest_valid, !msg_ready, "input taken during digest output")
	`SMH_ASSERT_NOW(a_last_flag, clk, arst_n, digest_valid, last_word == (word_index == smh_pkg::LAST_WORD_IDX), "last_word does not match word_index")
	`SMH_ASSERT_NEXT(a_word_step, clk, arst_n, digest_valid && digest_ready && !last_word, digest_valid && (word_index == 3'($past(word_index) + 3'd1)), "digest words out of sequence")
	`SMH_ASSERT_NEXT(a_back_idle, clk, arst_n, digest_valid && digest_ready && last_word, msg_ready && !digest_valid, "not ready after final digest word")
	`SMH_ASSERT_NEXT(a_hold_word, clk, arst_n, digest_valid && !digest_ready, digest_valid && $stable(digest_word) && $stable(word_index), "stalled digest word changed")

endmodule

bind sha256_message_hasher smh_checker u_smh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_ready    (msg_ready),
	.digest_valid (digest_valid),
	.digest_ready (digest_ready),
	.digest_word  (digest_word),
	.word_index   (word_index),
	.last_word    (last_word)
);
